// ===== design/circular_sweep_indicator_driver_assert.svh =====
// Assertion macros shared by the sweep indicator checker.
`ifndef CIRCULAR_SWEEP_INDICATOR_DRIVER_ASSERT_SVH
`define CIRCULAR_SWEEP_INDICATOR_DRIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define CSID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define CSID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/csid_pkg.sv =====
// Types, constants and helper functions for the circular sweep indicator driver.
package csid_pkg;

  localparam int unsigned TUBES_DEFAULT = 7;
  localparam int unsigned TUBES_MAX     = 64;

  localparam logic [5:0] RING_LAST     = 6'd59;
  localparam logic [6:0] RING_SIZE     = 7'd60;
  localparam logic [5:0] POS_RESET     = 6'd49;
  localparam logic       DIR_RESET     = 1'b0;
  localparam logic [5:0] LOW_RESET     = 6'd49;
  localparam logic [5:0] HIGH_RESET    = 6'd10;

  localparam logic MODE_STEP  = 1'b0;
  localparam logic MODE_BOUND = 1'b1;

  localparam logic DIR_DOWN = 1'b0;
  localparam logic DIR_UP   = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [2:0] channel;
    logic [5:0] low_end;
    logic [5:0] high_end;
  } csid_in_t;

  typedef struct packed {
    logic [2:0] tube;
    logic [6:0] pattern;
    logic [5:0] position;
    logic       direction;
  } csid_out_t;

  // Cathode drive per ring position; entries past the ring are unused.
  localparam logic [6:0] CATHODE_MAP [64] = '{
    7'd64, 7'd65, 7'd1,  7'd3,  7'd2,  7'd6,  7'd4,  7'd5,  7'd1,  7'd3,
    7'd2,  7'd6,  7'd4,  7'd5,  7'd1,  7'd3,  7'd2,  7'd6,  7'd4,  7'd5,
    7'd1,  7'd3,  7'd2,  7'd6,  7'd4,  7'd5,  7'd1,  7'd3,  7'd2,  7'd10,
    7'd8,  7'd9,  7'd1,  7'd3,  7'd2,  7'd6,  7'd4,  7'd5,  7'd1,  7'd3,
    7'd2,  7'd6,  7'd4,  7'd5,  7'd1,  7'd3,  7'd2,  7'd18, 7'd16, 7'd17,
    7'd1,  7'd3,  7'd2,  7'd34, 7'd32, 7'd33, 7'd1,  7'd3,  7'd2,  7'd66,
    7'd0,  7'd0,  7'd0,  7'd0
  };

  function automatic logic [6:0] cathode_pattern(input logic [5:0] p);
    return CATHODE_MAP[p];
  endfunction

  // (a - b) mod 60 for a, b on the ring.
  function automatic logic [5:0] ring_diff(input logic [5:0] a, input logic [5:0] b);
    logic [6:0] s;
    s = {1'b0, a} + RING_SIZE - {1'b0, b};
    if (s >= RING_SIZE) begin
      s = s - RING_SIZE;
    end
    return s[5:0];
  endfunction

  // Fold a 6-bit bound of 60..63 back onto the ring.
  function automatic logic [5:0] wrap_bound(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (w >= RING_SIZE) begin
      w = w - RING_SIZE;
    end
    return w[5:0];
  endfunction

endpackage

// ===== design/circular_sweep_indicator_driver.sv =====
// Top level of the circular sweep indicator driver: per-tube sweep state and result path.
//
//   channel | dir | valid       | ready       | payload
//   --------+-----+-------------+-------------+----------------------------
//   in      | in  | in_valid_i  | in_ready_o  | in_data_i  (csid_in_t)
//   out     | out | out_valid_o | out_ready_i | out_data_o (csid_out_t)
//
// A transaction accepted at one edge is held in the input register; the first edge at which the
// result register is free updates the tube state and loads the result register. One transaction
// per cycle is sustained while the output is not stalled; the tube state is updated in the same
// edge that loads the result, so back-to-back transactions on one tube see fresh state.
// Reset puts every tube at position 49, direction down, bounds 49 and 10.
// A stall on the output holds the result and backs up into the input register.
module circular_sweep_indicator_driver #(
  parameter int unsigned TUBES = csid_pkg::TUBES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  csid_pkg::csid_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csid_pkg::csid_out_t out_data_o
);

  localparam int unsigned IdxW = (TUBES > 1) ? $clog2(TUBES) : 1;

  // Input register stage.
  logic               in_valid_q;
  csid_pkg::csid_in_t in_q;

  // Result register stage.
  logic                out_valid_q;
  csid_pkg::csid_out_t out_q;
  csid_pkg::csid_out_t out_d;

  // Per-tube sweep state.
  logic [5:0] pos_q  [TUBES];
  logic       dir_q  [TUBES];
  logic [5:0] low_q  [TUBES];
  logic [5:0] high_q [TUBES];

  logic            out_free;
  logic            advance;
  logic            ch_ok;
  logic [IdxW-1:0] idx;
  logic [5:0]      cur_pos;
  logic            cur_dir;
  logic [5:0]      cur_low;
  logic [5:0]      cur_high;
  logic [5:0]      new_low;
  logic [5:0]      new_high;
  logic [5:0]      pos_d;
  logic            dir_d;

  // Handshake: the result register frees up when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Read the addressed tube.
  assign ch_ok    = (7'(in_q.channel) < 7'(TUBES));
  assign idx      = IdxW'(in_q.channel);
  assign cur_pos  = pos_q[idx];
  assign cur_dir  = dir_q[idx];
  assign cur_low  = low_q[idx];
  assign cur_high = high_q[idx];
  assign new_low  = csid_pkg::wrap_bound(in_q.low_end);
  assign new_high = csid_pkg::wrap_bound(in_q.high_end);

  // Next position and direction.
  always_comb begin
    pos_d = cur_pos;
    dir_d = cur_dir;
    if (in_q.mode == csid_pkg::MODE_STEP) begin
      if (cur_dir == csid_pkg::DIR_UP) begin
        // Reverse at the high bound, otherwise step up around the ring.
        if (cur_pos == cur_high) begin
          dir_d = csid_pkg::DIR_DOWN;
        end else if (cur_pos == csid_pkg::RING_LAST) begin
          pos_d = '0;
        end else begin
          pos_d = cur_pos + 6'd1;
        end
      end else begin
        if (cur_pos == cur_low) begin
          dir_d = csid_pkg::DIR_UP;
        end else if (cur_pos == '0) begin
          pos_d = csid_pkg::RING_LAST;
        end else begin
          pos_d = cur_pos - 6'd1;
        end
      end
    end else begin
      // Outside the span low->high: point the shorter way back in.
      if (csid_pkg::ring_diff(cur_pos, new_low) > csid_pkg::ring_diff(new_high, new_low)) begin
        if (csid_pkg::ring_diff(new_low, cur_pos) > csid_pkg::ring_diff(cur_pos, new_high)) begin
          dir_d = csid_pkg::DIR_DOWN;
        end else begin
          dir_d = csid_pkg::DIR_UP;
        end
      end
    end
  end

  // Result: a tube index beyond the fitted tubes reports zero pattern, position and direction.
  always_comb begin
    out_d.tube = in_q.channel;
    if (ch_ok) begin
      out_d.pattern   = csid_pkg::cathode_pattern(pos_d);
      out_d.position  = pos_d;
      out_d.direction = dir_d;
    end else begin
      out_d.pattern   = '0;
      out_d.position  = '0;
      out_d.direction = 1'b0;
    end
  end

  // Tube state write-back, same edge as the result load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TUBES; i++) begin
        pos_q[i]  <= csid_pkg::POS_RESET;
        dir_q[i]  <= csid_pkg::DIR_RESET;
        low_q[i]  <= csid_pkg::LOW_RESET;
        high_q[i] <= csid_pkg::HIGH_RESET;
      end
    end else if (advance && ch_ok) begin
      pos_q[idx] <= pos_d;
      dir_q[idx] <= dir_d;
      if (in_q.mode == csid_pkg::MODE_BOUND) begin
        low_q[idx]  <= new_low;
        high_q[idx] <= new_high;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/csid_checker.sv =====
// Port-level checker for the circular sweep indicator driver, bound to the top level.
`include "circular_sweep_indicator_driver_assert.svh"

module csid_checker #(
  parameter int unsigned TUBES = csid_pkg::TUBES_DEFAULT
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input csid_pkg::csid_out_t out_data_o
);

  logic                                 tube_ok;
  logic                                 stalled;
  logic                                 bad_tube;
  logic                                 good_tube;
  logic                                 zero_state;
  logic                                 pos_ok;
  logic                                 pattern_ok;
  logic [$bits(csid_pkg::csid_out_t):0] shown;

  assign tube_ok    = (7'(out_data_o.tube) < 7'(TUBES));
  assign stalled    = out_valid_o && !out_ready_i;
  assign bad_tube   = out_valid_o && !tube_ok;
  assign good_tube  = out_valid_o && tube_ok;
  assign zero_state = (out_data_o.pattern == '0) && (out_data_o.position == '0) &&
                      (out_data_o.direction == 1'b0);
  assign pos_ok     = (out_data_o.position <= csid_pkg::RING_LAST);
  assign pattern_ok = (out_data_o.pattern == csid_pkg::cathode_pattern(out_data_o.position));
  assign shown      = {out_valid_o, out_data_o};

  `CSID_ASSERT_NEXT(a_out_hold, stalled, $stable(shown), "result changed while stalled")

  `CSID_ASSERT_NOW(a_bad_tube_zero, bad_tube, zero_state, "unfitted tube reported nonzero state")

  `CSID_ASSERT_NOW(a_pos_on_ring, good_tube, pos_ok, "position left the ring")

  `CSID_ASSERT_NOW(a_pattern_match, good_tube, pattern_ok, "pattern does not match position")

endmodule

bind circular_sweep_indicator_driver csid_checker #(.TUBES(TUBES)) u_csid_checker (.*);
